// ===== rtl/skf3_pkg.sv =====
package skf3_pkg;

  localparam int unsigned NumCh   = 3;
  localparam int unsigned ChW     = 2;
  localparam int unsigned DataW   = 32;
  localparam int unsigned NoiseW  = 24;
  localparam int unsigned DtW     = 16;
  localparam int unsigned CfgIdxW = 3;

  // shared multiplier: 33 x 25 unsigned
  localparam int unsigned MulAW = 33;
  localparam int unsigned MulBW = 25;
  localparam int unsigned MulW  = MulAW + MulBW;

  // gain bits below the integer bit, one per step after the first
  localparam int unsigned DivSteps = 24;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [13:0]          GrowthFrac = 14'd8719;   // 1.00000203 - 1, Q0.32
  localparam logic [MulBW-1:0]     KOne       = 25'h100_0000;
  localparam logic signed [31:0]   MassInit   = 32'sd104857600; // 1600.0
  localparam logic [31:0]          VarInit    = 32'h0100_0000;  // 1.0 in Q8.24
  localparam logic [NoiseW-1:0]    NoiseInit  = 24'h01_0000;    // 1.0 in Q8.16

  typedef enum logic [ChW-1:0] {
    CH_MASS  = 2'd0,
    CH_ROLL  = 2'd1,
    CH_PITCH = 2'd2,
    CH_NONE  = 2'd3
  } chan_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_Q_MASS  = 3'd0,
    REG_R_MASS  = 3'd1,
    REG_Q_ROLL  = 3'd2,
    REG_R_ROLL  = 3'd3,
    REG_Q_PITCH = 3'd4,
    REG_R_PITCH = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GROW,
    ST_QQ,
    ST_QQ_HI,
    ST_QQ_LO,
    ST_RR,
    ST_DEN,
    ST_DIV_FIRST,
    ST_DIV,
    ST_CORR,
    ST_PNEW,
    ST_WRITE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_GROW,
    CMD_QQ,
    CMD_QQ_HI,
    CMD_QQ_LO,
    CMD_RR,
    CMD_DEN,
    CMD_DIV_FIRST,
    CMD_DIV_STEP,
    CMD_CORR,
    CMD_PNEW,
    CMD_WRITE
  } cmd_e;

endpackage

// ===== rtl/scalar_kalman_filter_3ch_top.sv =====
// Channel  | Direction | Handshake               | Payload
// in       | input     | in_valid_i / in_ready_o | func_i, measurement_i, time_step_i
// out      | output    | out_valid_o/out_ready_i | channel_out_o, estimate_o
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An item runs through setup (variance growth, q*q, two q*q*dt products, r*r and the
// denominator), the 25-step restoring divider for the gain, then correction, the new
// variance and write-back; denominator, divider and write-back skip the multiplier.
// One item is in work at a time; the next is taken once the controller is idle.
// A held result stalls only the final write-back; the output register holds it.
// Reset restores the noise settings to 1.0, the variances to 1.0 and the estimates.
module scalar_kalman_filter_3ch_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [skf3_pkg::ChW-1:0]            func_i,
  input  logic signed [skf3_pkg::DataW-1:0]   measurement_i,
  input  logic [skf3_pkg::DtW-1:0]            time_step_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [skf3_pkg::ChW-1:0]            channel_out_o,
  output logic signed [skf3_pkg::DataW-1:0]   estimate_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [skf3_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [skf3_pkg::NoiseW-1:0]         cfg_data_i
);
  import skf3_pkg::*;

  cmd_e cmd;

  assign cfg_ready_o = 1'b1;

  skf3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  skf3_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (func_i),
    .measurement_i (measurement_i),
    .time_step_i   (time_step_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .channel_out_o (channel_out_o),
    .estimate_o    (estimate_o)
  );

endmodule

// ===== rtl/skf3_dp.sv =====
module skf3_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  skf3_pkg::cmd_e                    cmd_i,
  input  logic [skf3_pkg::ChW-1:0]          func_i,
  input  logic signed [skf3_pkg::DataW-1:0] measurement_i,
  input  logic [skf3_pkg::DtW-1:0]          time_step_i,
  input  logic                              cfg_valid_i,
  input  logic [skf3_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [skf3_pkg::NoiseW-1:0]       cfg_data_i,
  output logic [skf3_pkg::ChW-1:0]          channel_out_o,
  output logic signed [skf3_pkg::DataW-1:0] estimate_o
);
  import skf3_pkg::*;

  // per-channel state and noise settings
  logic [NoiseW-1:0]       q_q   [NumCh];
  logic [NoiseW-1:0]       r_q   [NumCh];
  logic signed [DataW-1:0] est_q [NumCh];
  logic [DataW-1:0]        var_q [NumCh];

  // working registers of one item
  logic [ChW-1:0]          ch_q;
  logic signed [DataW-1:0] z_q;
  logic [DtW-1:0]          dt_q;
  logic signed [DataW-1:0] x_q;
  logic [DataW-1:0]        p_q;
  logic [NoiseW-1:0]       qn_q;
  logic [NoiseW-1:0]       rn_q;
  logic [MulW-1:0]         mul_q;
  logic [13:0]             grow_q;
  logic [23:0]             qq_lo_q;
  logic [32:0]             psum_q;
  logic [39:0]             acc_q;
  logic [40:0]             den_q;
  logic [40:0]             rem_q;
  logic [MulBW-1:0]        k_q;
  logic [32:0]             mag_q;
  logic                    neg_q;
  logic signed [DataW-1:0] xn_q;
  logic [ChW-1:0]          chan_o_q;
  logic signed [DataW-1:0] est_o_q;

  logic [MulAW-1:0]  mul_a;
  logic [MulBW-1:0]  mul_b;
  logic [MulW-1:0]   mul_p;
  logic [MulBW-1:0]  k_eff;
  logic [45:0]       grow_sum;
  logic [40:0]       pred_sum;
  logic [DataW-1:0]  p_pred;
  logic [40:0]       den_sum;
  logic [41:0]       trial;
  logic [41:0]       trial_sub;
  logic              ge;
  logic [40:0]       rem_next;
  logic signed [32:0] diff;
  logic [32:0]       mag;
  logic [MulW-1:0]   corr_sum;
  logic [33:0]       corr;
  logic signed [34:0] xn_wide;
  logic signed [DataW-1:0] xn_sat;
  logic [MulW-1:0]   pnew_sum;

  // zero denominator only with P = 0: gain is taken as one
  assign k_eff = (den_q == '0) ? KOne : k_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i)
      CMD_GROW: begin
        mul_a = {1'b0, p_q};
        mul_b = {11'b0, GrowthFrac};
      end
      CMD_QQ: begin
        mul_a = {9'b0, qn_q};
        mul_b = {1'b0, qn_q};
      end
      CMD_QQ_HI: begin
        mul_a = {9'b0, mul_q[47:24]};
        mul_b = {9'b0, dt_q};
      end
      CMD_QQ_LO: begin
        mul_a = {9'b0, qq_lo_q};
        mul_b = {9'b0, dt_q};
      end
      CMD_RR: begin
        mul_a = {9'b0, rn_q};
        mul_b = {1'b0, rn_q};
      end
      CMD_CORR: begin
        mul_a = mag_q;
        mul_b = k_eff;
      end
      CMD_PNEW: begin
        mul_a = {1'b0, p_q};
        mul_b = KOne - k_eff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MulW'(mul_a) * MulW'(mul_b);

  assign grow_sum = mul_q[45:0] + 46'h0_8000_0000;

  // q*q*dt = (qq_hi*dt) + ((qq_lo*dt) >> 24) after the >>24
  assign pred_sum = {8'b0, psum_q} + {1'b0, acc_q} + {25'b0, mul_q[39:24]};
  assign p_pred   = (pred_sum[40:32] != '0) ? '1 : pred_sum[31:0];

  assign den_sum = {9'b0, p_q} + {1'b0, mul_q[47:8]};

  // restoring division, one quotient bit per cycle; first step takes the integer bit
  assign trial     = (cmd_i == CMD_DIV_FIRST) ? {10'b0, p_q} : {rem_q, 1'b0};
  assign trial_sub = trial - {1'b0, den_q};
  assign ge        = (trial >= {1'b0, den_q});
  assign rem_next  = ge ? trial_sub[40:0] : trial[40:0];

  assign diff = {z_q[31], z_q} - {x_q[31], x_q};
  assign mag  = diff[32] ? 33'(-diff) : 33'(diff);

  // round half away from zero on the magnitude
  assign corr_sum = mul_q + MulW'(24'h80_0000);
  assign corr     = corr_sum[57:24];
  assign xn_wide  = neg_q ? ({{3{x_q[31]}}, x_q} - {1'b0, corr})
                          : ({{3{x_q[31]}}, x_q} + {1'b0, corr});

  always_comb begin
    if (xn_wide > 35'sh0_7FFF_FFFF) begin
      xn_sat = 32'sh7FFF_FFFF;
    end else if (xn_wide < -35'sh0_8000_0000) begin
      xn_sat = -32'sh8000_0000;
    end else begin
      xn_sat = xn_wide[31:0];
    end
  end

  assign pnew_sum = mul_q + MulW'(24'h80_0000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCh; i++) begin
        q_q[i]   <= NoiseInit;
        r_q[i]   <= NoiseInit;
        var_q[i] <= VarInit;
        est_q[i] <= (i == int'(CH_MASS)) ? MassInit : '0;
      end
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_Q_MASS:  q_q[CH_MASS]  <= cfg_data_i;
          REG_R_MASS:  r_q[CH_MASS]  <= cfg_data_i;
          REG_Q_ROLL:  q_q[CH_ROLL]  <= cfg_data_i;
          REG_R_ROLL:  r_q[CH_ROLL]  <= cfg_data_i;
          REG_Q_PITCH: q_q[CH_PITCH] <= cfg_data_i;
          REG_R_PITCH: r_q[CH_PITCH] <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i == CMD_WRITE) begin
        est_q[ch_q] <= xn_q;
        var_q[ch_q] <= pnew_sum[55:24];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // the new variance product waits here while the write-back is stalled
    if (cmd_i != CMD_NONE) begin
      mul_q <= mul_p;
    end
    unique case (cmd_i)
      CMD_LOAD: begin
        ch_q <= func_i;
        z_q  <= measurement_i;
        dt_q <= time_step_i;
        x_q  <= est_q[func_i];
        p_q  <= var_q[func_i];
        qn_q <= q_q[func_i];
        rn_q <= r_q[func_i];
      end
      CMD_QQ: begin
        grow_q <= grow_sum[45:32];
      end
      CMD_QQ_HI: begin
        qq_lo_q <= mul_q[23:0];
        psum_q  <= {1'b0, p_q} + {19'b0, grow_q};
      end
      CMD_QQ_LO: begin
        acc_q <= mul_q[39:0];
      end
      CMD_RR: begin
        p_q <= p_pred;
      end
      CMD_DEN: begin
        den_q <= den_sum;
      end
      CMD_DIV_FIRST: begin
        rem_q <= rem_next;
        k_q   <= {24'b0, ge};
        mag_q <= mag;
        neg_q <= diff[32];
      end
      CMD_DIV_STEP: begin
        rem_q <= rem_next;
        k_q   <= {k_q[MulBW-2:0], ge};
      end
      CMD_PNEW: begin
        xn_q <= xn_sat;
      end
      CMD_WRITE: begin
        chan_o_q <= ch_q;
        est_o_q  <= xn_q;
      end
      default: ;
    endcase
  end

  assign channel_out_o = chan_o_q;
  assign estimate_o    = est_o_q;

endmodule

// ===== rtl/skf3_ctrl.sv =====
module skf3_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [skf3_pkg::ChW-1:0] func_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output skf3_pkg::cmd_e           cmd_o
);
  import skf3_pkg::*;

  state_e             state_q, state_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic               out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = CMD_NONE;
    in_ready_o  = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        // channel select 3 is taken and dropped
        if (in_valid_i && (func_i != CH_NONE)) begin
          cmd_o   = CMD_LOAD;
          state_d = ST_GROW;
        end
      end
      ST_GROW: begin
        cmd_o   = CMD_GROW;
        state_d = ST_QQ;
      end
      ST_QQ: begin
        cmd_o   = CMD_QQ;
        state_d = ST_QQ_HI;
      end
      ST_QQ_HI: begin
        cmd_o   = CMD_QQ_HI;
        state_d = ST_QQ_LO;
      end
      ST_QQ_LO: begin
        cmd_o   = CMD_QQ_LO;
        state_d = ST_RR;
      end
      ST_RR: begin
        cmd_o   = CMD_RR;
        state_d = ST_DEN;
      end
      ST_DEN: begin
        cmd_o   = CMD_DEN;
        state_d = ST_DIV_FIRST;
      end
      ST_DIV_FIRST: begin
        cmd_o     = CMD_DIV_FIRST;
        div_cnt_d = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o     = CMD_DIV_STEP;
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = ST_CORR;
        end
      end
      ST_CORR: begin
        cmd_o   = CMD_CORR;
        state_d = ST_PNEW;
      end
      ST_PNEW: begin
        cmd_o   = CMD_PNEW;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        // wait for the output slot to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o       = CMD_WRITE;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/skf3_checker.sv =====
module skf3_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [skf3_pkg::ChW-1:0]          func_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [skf3_pkg::ChW-1:0]          channel_out_o,
  input logic signed [skf3_pkg::DataW-1:0] estimate_o
);
  import skf3_pkg::*;

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(estimate_o)
      && $stable(channel_out_o))
    else $error("result dropped or changed while stalled");

  a_out_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> channel_out_o != CH_NONE)
    else $error("result on unused channel");

  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (func_i != CH_NONE) |=> !in_ready_o)
    else $error("took a second item while one is in work");

  a_drop_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (func_i == CH_NONE) |=> in_ready_o)
    else $error("item on unused channel started work");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an item in work");

endmodule

bind scalar_kalman_filter_3ch_top skf3_checker u_skf3_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import skf3_pkg::*;

  localparam int unsigned PhaseCount    = 9;
  localparam int unsigned ItemsPerPhase = 120;
  localparam int unsigned SettleCycles  = 48;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned MaxReports    = 40;
  localparam longint      TimeoutNs     = 4_000_000;

  localparam logic [63:0]        GrowFracQ32 = 64'd8719;     // 1.00000203 - 1
  localparam logic [63:0]        GainOne     = 64'h100_0000; // 1.0 in Q40.24
  localparam logic signed [31:0] MassStart   = 32'sd104857600;
  localparam logic [31:0]        VarStart    = 32'h0100_0000;
  localparam logic [NoiseW-1:0]  NoiseStart  = 24'h01_0000;
  localparam logic [NoiseW-1:0]  NoiseMax    = 24'hFF_FFFF;
  localparam logic signed [31:0] ZMax        = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ZMin        = 32'sh8000_0000;
  localparam logic [DtW-1:0]     DtMax       = 16'hFFFF;

  // indexes past the last register, written to check they are ignored
  localparam logic [CfgIdxW-1:0] RegUnusedA = 3'd6;
  localparam logic [CfgIdxW-1:0] RegUnusedB = 3'd7;

  typedef enum logic [1:0] {
    JOB_FILTER,
    JOB_WRITE,
    JOB_DRAIN
  } job_kind_e;

  typedef struct packed {
    job_kind_e          kind;
    chan_e              ch;
    logic signed [31:0] z;
    logic [DtW-1:0]     dt;
    logic [CfgIdxW-1:0] idx;
    logic [NoiseW-1:0]  data;
    int unsigned        gap;
  } stim_job_t;

  typedef struct packed {
    chan_e              ch;
    logic signed [31:0] est;
  } est_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                      in_valid    = 1'b0;
  logic                      in_ready;
  logic [ChW-1:0]            func        = '0;
  logic signed [DataW-1:0]   measurement = '0;
  logic [DtW-1:0]            time_step   = '0;
  logic                      out_valid;
  logic                      out_ready   = 1'b0;
  logic [ChW-1:0]            channel_out;
  logic signed [DataW-1:0]   estimate;
  logic                      cfg_valid   = 1'b0;
  logic                      cfg_ready;
  logic [CfgIdxW-1:0]        cfg_index   = '0;
  logic [NoiseW-1:0]         cfg_data    = '0;

  // filter state as the testbench tracks it
  logic signed [31:0] est_state [NumCh];
  logic [31:0]        var_state [NumCh];
  logic [NoiseW-1:0]  q_noise   [NumCh];
  logic [NoiseW-1:0]  r_noise   [NumCh];

  stim_job_t   job_q[$];
  est_result_t est_expect_q[$];

  int unsigned gap_left;
  bit          draining;
  int unsigned hold_left;
  int unsigned n_results;
  int unsigned n_errors;
  logic signed [31:0] truth [NumCh];

  scalar_kalman_filter_3ch_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .measurement_i (measurement),
    .time_step_i   (time_step),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .channel_out_o (channel_out),
    .estimate_o    (estimate),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // One filter update; returns 0 for the unused channel code, which changes nothing.
  function automatic bit filter_update(input chan_e ch, input logic signed [31:0] z_in,
                                       input logic [DtW-1:0] dt_in,
                                       output logic signed [31:0] x_out);
    int                 c;
    logic [63:0]        p, q, r, rr, den, k, mag, corr;
    logic signed [63:0] x, z, diff, xn;
    bit                 neg;
    x_out = '0;
    if (ch == CH_NONE) return 1'b0;
    c = int'(ch);
    q = 64'(q_noise[c]);
    r = 64'(r_noise[c]);
    p = 64'(var_state[c]);
    x = est_state[c];
    z = z_in;

    p = p + ((p * GrowFracQ32 + 64'h8000_0000) >> 32) + ((q * q * 64'(dt_in)) >> 24);
    if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;

    rr  = (r * r) >> 8;
    den = p + rr;
    // zero denominator: take the full measurement
    k = (den == 64'd0) ? GainOne : (p << 24) / den;

    diff = z - x;
    neg  = diff < 0;
    mag  = neg ? 64'(-diff) : 64'(diff);
    corr = (mag * k + (GainOne >> 1)) >> 24;
    xn   = neg ? x - $signed(corr) : x + $signed(corr);
    if (xn > 64'sd2147483647) xn = 64'sd2147483647;
    if (xn < -64'sd2147483648) xn = -64'sd2147483648;

    p = (p * (GainOne - k) + (GainOne >> 1)) >> 24;
    var_state[c] = p[31:0];
    est_state[c] = xn[31:0];
    x_out = xn[31:0];
    return 1'b1;
  endfunction

  task automatic push_filter(input chan_e ch, input logic signed [31:0] z,
                             input logic [DtW-1:0] dt, input int unsigned gap);
    stim_job_t j;
    j = '0;
    j.kind = JOB_FILTER;
    j.ch   = ch;
    j.z    = z;
    j.dt   = dt;
    j.gap  = gap;
    job_q.push_back(j);
  endtask

  task automatic push_write(input logic [CfgIdxW-1:0] idx, input logic [NoiseW-1:0] data);
    stim_job_t j;
    j = '0;
    j.kind = JOB_WRITE;
    j.idx  = idx;
    j.data = data;
    job_q.push_back(j);
  endtask

  task automatic push_drain();
    stim_job_t j;
    j = '0;
    j.kind = JOB_DRAIN;
    job_q.push_back(j);
  endtask

  function automatic logic [NoiseW-1:0] draw_noise(input int unsigned ph);
    if (ph == 0) return NoiseMax;
    if (ph == 1) return '0;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return NoiseMax;
      2, 3:    return NoiseW'($urandom_range(0, 24'hFF_FFFF));
      4:       return NoiseW'($urandom_range(0, 15));  // r*r truncates to zero
      default: return NoiseW'($urandom_range(256, 24'h20_0000));
    endcase
  endfunction

  // sender: one item or register write in flight at a time
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    stim_job_t          job;
    est_result_t        res;
    logic signed [31:0] x_new;
    logic               fire_in, fire_cfg, keep_in, keep_cfg;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left  = 0;
      draining  = 1'b0;
    end else begin
      fire_in  = in_valid && in_ready;
      fire_cfg = cfg_valid && cfg_ready;
      if (fire_in && filter_update(chan_e'(func), measurement, time_step, x_new)) begin
        res.ch  = chan_e'(func);
        res.est = x_new;
        est_expect_q.push_back(res);
      end
      if (fire_cfg) begin
        case (cfg_index)
          REG_Q_MASS:  q_noise[0] = cfg_data;
          REG_R_MASS:  r_noise[0] = cfg_data;
          REG_Q_ROLL:  q_noise[1] = cfg_data;
          REG_R_ROLL:  r_noise[1] = cfg_data;
          REG_Q_PITCH: q_noise[2] = cfg_data;
          REG_R_PITCH: r_noise[2] = cfg_data;
          default: ;
        endcase
      end
      keep_in  = in_valid && !fire_in;
      keep_cfg = cfg_valid && !fire_cfg;
      if (!keep_in && !keep_cfg) begin
        if (draining) begin
          // wait until every expected result has come back, then let the design settle
          if (est_expect_q.size() == 0) begin
            draining = 1'b0;
            gap_left = SettleCycles;
          end
        end else if (gap_left != 0) begin
          gap_left--;
        end else if (job_q.size() != 0) begin
          job = job_q.pop_front();
          case (job.kind)
            JOB_FILTER: begin
              func        <= job.ch;
              measurement <= job.z;
              time_step   <= job.dt;
              keep_in     = 1'b1;
              gap_left    = job.gap;
            end
            JOB_WRITE: begin
              cfg_index <= job.idx;
              cfg_data  <= job.data;
              keep_cfg  = 1'b1;
            end
            default: draining = 1'b1;
          endcase
        end
      end
      in_valid  <= keep_in;
      cfg_valid <= keep_cfg;
    end
  end

  // receiver: random stalls, two long hold-offs, stretches with none
  always @(posedge clk_i or negedge rst_ni) begin : sink_proc
    est_result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left = 0;
      n_results = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (est_expect_q.size() == 0) begin
          if (n_errors < MaxReports)
            $display("%0t: unexpected item: channel %0d estimate %0d",
                     $time, channel_out, estimate);
          n_errors++;
        end else begin
          want = est_expect_q.pop_front();
          if (channel_out !== want.ch) begin
            if (n_errors < MaxReports)
              $display("%0t: channel_out mismatch: expected %0d actual %0d",
                       $time, want.ch, channel_out);
            n_errors++;
          end
          if (estimate !== want.est) begin
            if (n_errors < MaxReports)
              $display("%0t: estimate mismatch (channel %0d): expected %0d actual %0d",
                       $time, want.ch, want.est, estimate);
            n_errors++;
          end
        end
        if (n_results == 60 || n_results == 640) hold_left = LongHold;
        else if ((n_results / 48) % 3 == 0) hold_left = 0;
        else hold_left = $urandom_range(0, 11);
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_ready <= (hold_left == 0);
    end
  end

  initial begin
    int unsigned        n_valid;
    chan_e              ch;
    logic signed [31:0] z;
    logic [DtW-1:0]     dt;
    int unsigned        gap;
    n_errors = 0;
    for (int c = 0; c < NumCh; c++) begin
      est_state[c] = '0;
      var_state[c] = VarStart;
      q_noise[c]   = NoiseStart;
      r_noise[c]   = NoiseStart;
      truth[c]     = $urandom;
    end
    est_state[0] = MassStart;

    // directed: reset settings, extremes, ignored channel code
    push_filter(CH_MASS,  ZMax,  DtMax, $urandom_range(0, 11));
    push_filter(CH_ROLL,  ZMin,  '0,    $urandom_range(0, 11));
    push_filter(CH_PITCH, '0,    16'd1, 0);
    push_filter(CH_NONE,  32'sh1234, 16'd5, 0);
    push_filter(CH_MASS,  -32'sd1, DtMax, $urandom_range(0, 11));
    push_filter(CH_NONE,  ZMin,  DtMax, 0);

    // no process noise on pitch with r = 0: gain of one, then a zero denominator
    push_drain();
    push_write(REG_Q_MASS,  '0);
    push_write(REG_R_MASS,  NoiseMax);
    push_write(REG_Q_ROLL,  NoiseMax);
    push_write(REG_R_ROLL,  NoiseMax);
    push_write(REG_Q_PITCH, '0);
    push_write(REG_R_PITCH, '0);
    push_write(RegUnusedA,  24'hAB_CDEF);
    push_write(RegUnusedB,  NoiseMax);
    push_filter(CH_PITCH, 32'sh0001_0000, '0, 0);
    push_filter(CH_PITCH, ZMin,  DtMax, 0);
    push_filter(CH_PITCH, ZMax,  DtMax, $urandom_range(0, 11));
    push_filter(CH_ROLL,  ZMax,  DtMax, 0);  // variance saturates
    push_filter(CH_ROLL,  ZMin,  DtMax, 0);
    push_filter(CH_ROLL,  '0,    '0,    $urandom_range(0, 11));
    push_filter(CH_MASS,  '0,    DtMax, 0);
    push_filter(CH_MASS,  ZMax,  '0,    0);

    // small nonzero r whose square truncates to zero
    push_drain();
    push_write(REG_Q_PITCH, 24'd15);
    push_write(REG_R_PITCH, 24'd15);
    push_write(REG_Q_MASS,  NoiseMax);
    push_write(REG_R_MASS,  '0);
    push_write(REG_Q_ROLL,  24'd1);
    push_write(REG_R_ROLL,  24'h00_0100);
    push_filter(CH_PITCH, -32'sd1, DtMax, 0);
    push_filter(CH_MASS,  ZMin,  DtMax, 0);
    push_filter(CH_MASS,  ZMax,  16'd1, $urandom_range(0, 11));
    push_filter(CH_ROLL,  32'sd12345, 16'd100, 0);

    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      push_drain();
      push_write(REG_Q_MASS,  draw_noise(ph));
      push_write(REG_R_MASS,  draw_noise(ph));
      push_write(REG_Q_ROLL,  draw_noise(ph));
      push_write(REG_R_ROLL,  draw_noise(ph));
      push_write(REG_Q_PITCH, draw_noise(ph));
      push_write(REG_R_PITCH, draw_noise(ph));
      if ($urandom_range(0, 1)) push_write(RegUnusedA, NoiseW'($urandom));
      else push_write(RegUnusedB, NoiseW'($urandom));
      n_valid = 0;
      while (n_valid < ItemsPerPhase) begin
        if ($urandom_range(0, 15) == 0) ch = CH_NONE;
        else ch = chan_e'($urandom_range(0, 2));
        case ($urandom_range(0, 15))
          0:       z = ZMax;
          1:       z = ZMin;
          2, 3, 4: z = $urandom;
          default: begin
            // noisy readings around a slowly drifting value
            if (ch != CH_NONE) begin
              truth[int'(ch)] = truth[int'(ch)] + $signed($urandom_range(0, 32'h4_0000))
                                - 32'sh2_0000;
              z = truth[int'(ch)] + $signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000;
            end else begin
              z = $urandom;
            end
          end
        endcase
        case ($urandom_range(0, 7))
          0:       dt = '0;
          1:       dt = DtMax;
          2, 3:    dt = DtW'($urandom_range(0, 65535));
          default: dt = DtW'($urandom_range(0, 2048));
        endcase
        gap = ((n_valid / 40) % 3 == 1) ? 0 : $urandom_range(0, 11);
        push_filter(ch, z, dt, gap);
        if (ch != CH_NONE) n_valid++;
        if (ph == 4 && n_valid == 64 && ch != CH_NONE) push_drain();
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (job_q.size() != 0 || in_valid || cfg_valid) @(posedge clk_i);
    while (est_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("%0t: timeout, %0d results outstanding", $time, est_expect_q.size());
    $display("FAIL");
    $finish;
  end

endmodule

// ===== scalar_kalman_filter_3ch_top.f =====
rtl/skf3_pkg.sv
rtl/skf3_dp.sv
rtl/skf3_ctrl.sv
rtl/scalar_kalman_filter_3ch_top.sv
rtl/skf3_checker.sv
tb/tb.sv
